// ----- rtl/core/xcfp_pkg.sv -----
// ----------------------------------------------------------------------------
// xcfp_pkg
// Shared types and constants for the XOR-checksum frame parser.
// ----------------------------------------------------------------------------
package xcfp_pkg;

  // Frame sync marker
  localparam logic [7:0] SYNC_BYTE = 8'h5A;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // Parser phase
  typedef enum logic [2:0] {
    PH_SYNC    = 3'd0,
    PH_CMD     = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } xcfp_phase_t;

  // One result word as it leaves the parser
  typedef struct packed {
    logic        kind;
    logic [7:0]  command;
    logic [15:0] frame_length;
    logic [15:0] byte_index;
    logic [7:0]  data_byte;
    logic        checksum_ok;
    logic        last;
  } xcfp_res_t;

  // Handoff from the input register to the parser
  typedef struct packed {
    logic       vld;
    logic [7:0] rx_byte;
  } xcfp_byte_t;

endpackage

// ----- rtl/core/xcfp_in_if.sv -----
// ----------------------------------------------------------------------------
// xcfp_in_if
// Input channel: one received byte per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface xcfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/xcfp_out_if.sv -----
// ----------------------------------------------------------------------------
// xcfp_out_if
// Result channel: payload bytes and frame-end words, valid/ready handshake.
// ----------------------------------------------------------------------------
interface xcfp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  command;
  logic [15:0] frame_length;
  logic [15:0] byte_index;
  logic [7:0]  data_byte;
  logic        checksum_ok;
  logic        last;

  modport source (output valid, output kind, output command, output frame_length,
                  output byte_index, output data_byte, output checksum_ok,
                  output last, input ready);
  modport sink   (input valid, input kind, input command, input frame_length,
                  input byte_index, input data_byte, input checksum_ok,
                  input last, output ready);
endinterface

// ----- rtl/core/xcfp_in_stage.sv -----
// ----------------------------------------------------------------------------
// xcfp_in_stage
// Input register: captures one byte and hands it to the parser on advance.
// ----------------------------------------------------------------------------
module xcfp_in_stage import xcfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       adv,       // parser consumes the held byte this cycle
  output xcfp_byte_t held
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;
  logic       take;

  // Free when empty or being drained this cycle
  assign in_ready = !vld_r || adv;
  assign take     = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte;
    end
  end

  assign held.vld     = vld_r;
  assign held.rx_byte = byte_r;

endmodule

// ----- rtl/core/xcfp_parser.sv -----
// ----------------------------------------------------------------------------
// xcfp_parser
// Frame state machine: header decode, running XOR, payload index and check.
// ----------------------------------------------------------------------------
module xcfp_parser import xcfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,      // process held byte this cycle
  input  logic [7:0] rx_byte,
  output logic       res_vld,
  output xcfp_res_t  res
);

  xcfp_phase_t phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] cnt_inc;

  assign cnt_inc = cnt_r + 16'd1;

  // Next state and result
  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    xor_nxt   = xor_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    res_vld   = 1'b0;

    res.kind         = KIND_PAYLOAD;
    res.command      = cmd_r;
    res.frame_length = len_r;
    res.byte_index   = cnt_r;
    res.data_byte    = rx_byte;
    res.checksum_ok  = 1'b0;
    res.last         = 1'b0;

    if (fire) begin
      case (phase_r)
        PH_CMD: begin
          cmd_nxt   = rx_byte;
          xor_nxt   = rx_byte;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt   = {8'd0, rx_byte};
          xor_nxt   = xor_r ^ rx_byte;
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_nxt   = {rx_byte, len_r[7:0]};
          xor_nxt   = xor_r ^ rx_byte;
          cnt_nxt   = 16'd0;
          // zero-length frame skips straight to checksum
          phase_nxt = ({rx_byte, len_r[7:0]} == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          res_vld = 1'b1;
          xor_nxt = xor_r ^ rx_byte;
          cnt_nxt = cnt_inc;
          if (cnt_inc == len_r) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          res_vld         = 1'b1;
          res.kind        = KIND_END;
          res.data_byte   = 8'd0;
          res.checksum_ok = (rx_byte == xor_r);
          res.last        = 1'b1;
          phase_nxt       = PH_SYNC;
        end
        default: begin
          // wait for sync; unused codes behave the same
          phase_nxt = (rx_byte == SYNC_BYTE) ? PH_CMD : PH_SYNC;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC;
      cmd_r   <= 8'd0;
      xor_r   <= 8'd0;
      len_r   <= 16'd0;
      cnt_r   <= 16'd0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      xor_r   <= xor_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/xcfp_out_stage.sv -----
// ----------------------------------------------------------------------------
// xcfp_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module xcfp_out_stage import xcfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,       // new result from parser
  input  xcfp_res_t res,
  output logic      room,       // can take a word this cycle
  output logic      out_valid,
  input  logic      out_ready,
  output xcfp_res_t out_word
);

  logic      vld_r;
  logic      vld_nxt;
  xcfp_res_t word_r;

  assign room = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_word  = word_r;

endmodule

// ----- rtl/core/xor_checksum_frame_parser.sv -----
// An accepted byte waits in the input register, then goes through the parser into the result register.
// Throughput: one byte per cycle while the result register has room; a stalled sink holds the input.
// Header and sync bytes produce no result word; payload and checksum bytes produce one.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to
// waiting for sync with command, XOR, length and count cleared.
// ----------------------------------------------------------------------------
// xor_checksum_frame_parser
// Sync/length/XOR-checksum deframer, cut-through: input register, parser,
// result register.
// ----------------------------------------------------------------------------
module xor_checksum_frame_parser import xcfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  xcfp_in_if.sink    in_bus,
  xcfp_out_if.source out_bus
);

  xcfp_byte_t held;
  logic       room;
  logic       adv;
  logic       res_vld;
  xcfp_res_t  res;
  xcfp_res_t  out_word;

  // Held byte moves into the parser when the result register has room
  assign adv = held.vld && room;

  xcfp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .in_byte  (in_bus.rx_byte),
    .adv      (adv),
    .held     (held)
  );

  xcfp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (adv),
    .rx_byte (held.rx_byte),
    .res_vld (res_vld),
    .res     (res)
  );

  xcfp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && res_vld),
    .res       (res),
    .room      (room),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_word  (out_word)
  );

  // Result word onto the channel
  assign out_bus.kind         = out_word.kind;
  assign out_bus.command      = out_word.command;
  assign out_bus.frame_length = out_word.frame_length;
  assign out_bus.byte_index   = out_word.byte_index;
  assign out_bus.data_byte    = out_word.data_byte;
  assign out_bus.checksum_ok  = out_word.checksum_ok;
  assign out_bus.last         = out_word.last;

endmodule

// ----- tb/xcfp_frame_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xcfp_frame_checker
// Watches both channels of the frame parser. It tracks the frame state for every
// accepted byte, queues the result word each byte should produce, and compares
// every accepted result word field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module xcfp_frame_checker import xcfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  xcfp_in_if   in_mon,
  xcfp_out_if  out_mon,
  output int   fail_count,
  output int   pending_words,
  output int   bytes_seen,
  output int   payload_words,
  output int   frames_good,
  output int   frames_bad
);

  // Frame tracking state
  xcfp_phase_t phase_q;
  logic [7:0]  cmd_q;
  logic [7:0]  xor_q;
  logic [15:0] len_q;
  logic [15:0] count_q;

  xcfp_res_t   expected_words[$];
  int          errors;
  int          n_bytes;
  int          n_payload;
  int          n_good;
  int          n_bad;

  // Advance the frame state by one byte; returns 1 when the byte makes a word
  function automatic bit parse_rx_byte(input logic [7:0] b, output xcfp_res_t word);
    bit has_word;
    has_word = 1'b0;
    word     = '0;
    case (phase_q)
      PH_CMD: begin
        cmd_q   = b;
        xor_q   = b;
        phase_q = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_q   = {8'h00, b};
        xor_q   = xor_q ^ b;
        phase_q = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_q[15:8] = b;
        xor_q       = xor_q ^ b;
        count_q     = '0;
        phase_q     = (len_q == 16'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        word.kind         = KIND_PAYLOAD;
        word.command      = cmd_q;
        word.frame_length = len_q;
        word.byte_index   = count_q;
        word.data_byte    = b;
        xor_q             = xor_q ^ b;
        count_q           = count_q + 16'd1;
        if (count_q == len_q) phase_q = PH_CHECK;
        has_word = 1'b1;
      end
      PH_CHECK: begin
        word.kind         = KIND_END;
        word.command      = cmd_q;
        word.frame_length = len_q;
        word.byte_index   = count_q;
        word.checksum_ok  = (b == xor_q);
        word.last         = 1'b1;
        phase_q           = PH_SYNC;
        has_word          = 1'b1;
      end
      // waiting for sync; any other byte is dropped
      default: begin
        phase_q = (b == SYNC_BYTE) ? PH_CMD : PH_SYNC;
      end
    endcase
    return has_word;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  // Compare result words first, then account for the byte taken at this edge
  always @(posedge clk) begin
    xcfp_res_t seen;
    xcfp_res_t want;
    if (!rst_n) begin
      phase_q = PH_SYNC;
      cmd_q   = '0;
      xor_q   = '0;
      len_q   = '0;
      count_q = '0;
      expected_words.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen.kind         = out_mon.kind;
        seen.command      = out_mon.command;
        seen.frame_length = out_mon.frame_length;
        seen.byte_index   = out_mon.byte_index;
        seen.data_byte    = out_mon.data_byte;
        seen.checksum_ok  = out_mon.checksum_ok;
        seen.last         = out_mon.last;
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got kind %0d cmd 0x%0h idx %0d",
                   $time, seen.kind, seen.command, seen.byte_index);
        end else begin
          want = expected_words.pop_front();
          check_field("kind", want.kind, seen.kind);
          check_field("command", want.command, seen.command);
          check_field("frame_length", want.frame_length, seen.frame_length);
          check_field("byte_index", want.byte_index, seen.byte_index);
          check_field("data_byte", want.data_byte, seen.data_byte);
          check_field("checksum_ok", want.checksum_ok, seen.checksum_ok);
          check_field("last", want.last, seen.last);
        end
        if (seen.kind == KIND_END) begin
          if (seen.checksum_ok) n_good++;
          else n_bad++;
        end else begin
          n_payload++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        n_bytes++;
        // append at the tail of the expected queue
        if (parse_rx_byte(in_mon.rx_byte, want)) expected_words = {expected_words, want};
      end
    end
    fail_count    <= errors;
    pending_words <= expected_words.size();
    bytes_seen    <= n_bytes;
    payload_words <= n_payload;
    frames_good   <= n_good;
    frames_bad    <= n_bad;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream stimulus for the XOR-checksum frame parser: a few hand-built
// frames, then random good, corrupted and cut-short frames mixed with line
// noise, with random gaps and stalls on both channels, and frames whose
// length needs the high length byte. The checker beside the block does all
// of the comparing.
// ----------------------------------------------------------------------------
module tb_top;
  import xcfp_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_BYTES = 1000;
  localparam int HOLD_CYCLES  = 160;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;

  xcfp_in_if  in_if ();
  xcfp_out_if out_if ();

  int fail_count;
  int pending_words;
  int bytes_seen;
  int payload_words;
  int frames_good;
  int frames_bad;

  int bytes_sent;
  int holds_done;
  int idle_cycles;
  bit tx_steady;   // sender offers back to back when set
  bit hold_req;    // asks the receiver for a long hold-off

  xor_checksum_frame_parser u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  xcfp_frame_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .bytes_seen    (bytes_seen),
    .payload_words (payload_words),
    .frames_good   (frames_good),
    .frames_bad    (frames_bad)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Any byte but the sync marker
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == SYNC_BYTE) b = ~b;
    return b;
  endfunction

  function automatic logic [7:0] payload_byte();
    if ($urandom_range(0, 9) == 0) return SYNC_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly short payloads, a few empty, a few long ones
  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 95) return 16'($urandom_range(1, 16));
    if (r < 97) return 16'h005A;
    if ($urandom_range(0, 1) == 0) return 16'h015A;
    return 16'($urandom_range(240, 300));
  endfunction

  // Offer one byte, optionally after a gap, and wait for it to be taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!tx_steady) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_if.valid   <= 1'b0;
        in_if.rx_byte <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
  endtask

  // Whole frame; a clean frame carries no sync byte after its first one
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                            input bit good, input bit clean);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] chk;
    if (clean && cmd == SYNC_BYTE) cmd = cmd ^ 8'h01;
    sum = cmd ^ len[7:0] ^ len[15:8];
    send_byte(SYNC_BYTE);
    send_byte(cmd);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    for (int i = 0; i < int'(len); i++) begin
      b   = clean ? plain_byte() : payload_byte();
      sum = sum ^ b;
      send_byte(b);
    end
    chk = good ? sum : sum ^ 8'($urandom_range(1, 255));
    if (clean && chk == SYNC_BYTE) chk = SYNC_BYTE ^ 8'h80;
    send_byte(chk);
  endtask

  // Header promises more payload than follows; the next frame is clean so the
  // parser is back in sync once the short frame has swallowed its front part
  task automatic send_cut_frame();
    int len_decl;
    int kept;
    len_decl = $urandom_range(2, 8);
    kept     = $urandom_range(0, len_decl - 1);
    send_byte(SYNC_BYTE);
    send_byte(8'($urandom));
    send_byte(8'(len_decl));
    send_byte(8'h00);
    repeat (kept) send_byte(payload_byte());
    send_frame(plain_byte(), 16'($urandom_range(8, 16)), 1'b1, 1'b1);
  endtask

  // Result side: random stalls in some stretches, none in others, long hold on request
  initial begin
    int stall_left;
    int calm_left;
    bit calm;
    out_if.ready <= 1'b0;
    stall_left = 0;
    calm       = 1'b0;
    calm_left  = 100;
    holds_done = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        if (stall_left > 0) begin
          out_if.ready <= 1'b0;
          stall_left--;
        end else begin
          out_if.ready <= 1'b1;
          if (!calm && $urandom_range(0, 4) == 0) stall_left = pick_gap();
        end
        @(posedge clk);
        calm_left--;
        if (calm_left == 0) begin
          calm      = !calm;
          calm_left = $urandom_range(30, 300);
        end
      end
    end
  end

  // Watchdog: no word moving on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int frames;
    int pick;
    int directed_bytes;
    in_if.valid   <= 1'b0;
    in_if.rx_byte <= 8'h00;
    rst_n         <= 1'b0;
    tx_steady  = 1'b0;
    hold_req   = 1'b0;
    bytes_sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Noise before any sync
    send_byte(8'h00);
    send_byte(8'hFF);
    // Empty frame, good checksum
    send_frame(8'hFF, 16'h0000, 1'b1, 1'b0);
    // Two payload bytes, sync value among them, wrong checksum (good one is 0xA7)
    send_byte(SYNC_BYTE);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(SYNC_BYTE);
    send_byte(8'hFF);
    send_byte(8'h58);
    // Sync value as command and as a correct checksum
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(SYNC_BYTE);
    directed_bytes = bytes_sent;

    // Random frames, mostly well formed
    frames = 0;
    while (bytes_sent - directed_bytes < RANDOM_BYTES) begin
      tx_steady = ($urandom_range(0, 9) < 3);
      if (frames == 5 || frames == 30) begin
        hold_req  = 1'b1;
        tx_steady = 1'b1;
        send_frame(8'($urandom), 16'd40, 1'b1, 1'b0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          repeat ($urandom_range(1, 4)) send_byte(plain_byte());
        end else if (pick < 14) begin
          send_cut_frame();
        end else begin
          send_frame(8'($urandom), pick_len(), ($urandom_range(0, 99) < 85), 1'b0);
        end
      end
      frames++;
    end

    // Short frame at the end to show the parser is in sync
    tx_steady = 1'b0;
    send_frame(8'($urandom), 16'd3, 1'b1, 1'b0);
    in_if.valid <= 1'b0;

    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d bytes in, %0d payload words, %0d frame ends (%0d good, %0d bad)",
             bytes_seen, payload_words, frames_good + frames_bad, frames_good, frames_bad);
    $display("Frames up to 346 payload bytes; %0d long result hold-offs with input stalled",
             holds_done);
    if (fail_count == 0 && pending_words == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
